// File: sv/line_follow_motor_steering_top_assert.svh
// assertion macros for the line follow motor steering block
`ifndef LINE_FOLLOW_MOTOR_STEERING_TOP_ASSERT_SVH
`define LINE_FOLLOW_MOTOR_STEERING_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define LFMS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lfms assertion failed");

// implication whose consequent is checked in the next cycle
`define LFMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfms assertion failed");

`else

`define LFMS_ASSERT(lbl, prop)
`define LFMS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/lfms_pkg.sv
package lfms_pkg;

    // input beat, first field in the top bits
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_rate;
        logic [9:0]         ir_left;
        logic [9:0]         ir_right;
        logic               button;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [15:0] motor_left;
        logic [15:0] motor_right;
        logic [3:0]  direction_code;
        logic        light_mode;
    } out_beat_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_BASE_POWER   = 3'd0,
        CFG_STEER_GAIN   = 3'd1,
        CFG_LEFT_WHITE   = 3'd2,
        CFG_LEFT_GRAY    = 3'd3,
        CFG_LEFT_BLACK   = 3'd4,
        CFG_RIGHT_WHITE  = 3'd5,
        CFG_RIGHT_GRAY   = 3'd6,
        CFG_RIGHT_BLACK  = 3'd7
    } cfg_index_t;

    // sensor tone classes
    typedef enum logic [1:0] {
        TONE_BLACK = 2'd1,
        TONE_GRAY  = 2'd2,
        TONE_WHITE = 2'd3
    } tone_t;

    // direction codes
    localparam logic [3:0] DIR_BOTH_WHITE  = 4'd0;
    localparam logic [3:0] DIR_WHITE_GRAY  = 4'd1;
    localparam logic [3:0] DIR_WHITE_BLACK = 4'd2;
    localparam logic [3:0] DIR_GRAY_GRAY   = 4'd3;
    localparam logic [3:0] DIR_GRAY_BLACK  = 4'd4;
    localparam logic [3:0] DIR_BLACK_GRAY  = 4'd5;
    localparam logic [3:0] DIR_BLACK_BLACK = 4'd6;
    localparam logic [3:0] DIR_GRAY_WHITE  = 4'd7;
    localparam logic [3:0] DIR_BLACK_WHITE = 4'd8;

    // turning states
    localparam logic [1:0] TURN_NONE  = 2'd0;
    localparam logic [1:0] TURN_RIGHT = 2'd1;
    localparam logic [1:0] TURN_LEFT  = 2'd2;

    // register reset values
    localparam logic [15:0] BASE_POWER_RST  = 16'h70FF;
    localparam logic [7:0]  STEER_GAIN_RST  = 8'd20;
    localparam logic [9:0]  LEFT_WHITE_RST  = 10'd700;
    localparam logic [9:0]  LEFT_GRAY_RST   = 10'd370;
    localparam logic [9:0]  LEFT_BLACK_RST  = 10'd18;
    localparam logic [9:0]  RIGHT_WHITE_RST = 10'd700;
    localparam logic [9:0]  RIGHT_GRAY_RST  = 10'd370;
    localparam logic [9:0]  RIGHT_BLACK_RST = 10'd40;

    // control constants
    localparam logic [12:0] SHAKE_LIMIT = 13'd2500;
    localparam logic [8:0]  LOCK_TICKS  = 9'd500;
    localparam logic [15:0] FULL_DUTY   = 16'hFFFF;
    localparam logic [15:0] WEAK_DUTY   = 16'h4E20;
    localparam logic [15:0] PIVOT_DUTY  = 16'hEA60;
    localparam logic signed [15:0] RATE_HIGH   = 16'sd50;
    localparam logic signed [15:0] RATE_LOW    = -16'sd40;
    localparam logic signed [15:0] DRIFT_RIGHT = 16'sd10;
    localparam logic signed [15:0] DRIFT_LEFT  = -16'sd5;

    // divide by ten as multiply by 2^19/10 rounded up, exact for 16-bit magnitudes
    localparam logic [15:0] RATE_RECIP = 16'd52429;
    localparam int unsigned RATE_SHIFT = 19;

    // magnitude of a signed 16-bit value, -32768 gives 32768
    function automatic logic [15:0] mag16(input logic [15:0] v);
        mag16 = v[15] ? (16'd0 - v) : v;
    endfunction

    // absolute difference of two 10-bit levels
    function automatic logic [9:0] diff10(input logic [9:0] a, input logic [9:0] b);
        diff10 = (a >= b) ? (a - b) : (b - a);
    endfunction

    // nearest reference level, gray wins ties
    function automatic tone_t classify(input logic [9:0] x, input logic [9:0] w,
                                       input logic [9:0] g, input logic [9:0] b);
        logic [9:0] dg;
        dg = diff10(x, g);
        if (diff10(x, w) < dg)
            classify = TONE_WHITE;
        else if (diff10(x, b) < dg)
            classify = TONE_BLACK;
        else
            classify = TONE_GRAY;
    endfunction

    // sensor pair to direction code
    function automatic logic [3:0] pair_code(input tone_t l, input tone_t r);
        logic [3:0] c;
        c = DIR_BOTH_WHITE;
        if (l == TONE_WHITE && r == TONE_GRAY)  c = DIR_WHITE_GRAY;
        if (l == TONE_WHITE && r == TONE_BLACK) c = DIR_WHITE_BLACK;
        if (l == TONE_GRAY  && r == TONE_GRAY)  c = DIR_GRAY_GRAY;
        if (l == TONE_GRAY  && r == TONE_BLACK) c = DIR_GRAY_BLACK;
        if (l == TONE_BLACK && r == TONE_GRAY)  c = DIR_BLACK_GRAY;
        if (l == TONE_BLACK && r == TONE_BLACK) c = DIR_BLACK_BLACK;
        if (l == TONE_GRAY  && r == TONE_WHITE) c = DIR_GRAY_WHITE;
        if (l == TONE_BLACK && r == TONE_WHITE) c = DIR_BLACK_WHITE;
        pair_code = c;
    endfunction

endpackage

// File: sv/line_follow_motor_steering_top.sv
// Line-follow motor steering controller. Each input beat is one control tick and gives
// exactly one result beat with both motor duties, the direction code and the light mode.
// Two register stages: the input stage classifies the reflectance sensors, scales the gyro
// rate and flags a shake; the result stage updates heading, lockout and turning state and
// works out the duties with one 16x8 multiply. A tick is accepted every cycle when the
// result side is not stalled. A tick is registered in the input stage, and its result beat
// then in the result register; a result-side stall can hold either of them. Write
// configuration only while no tick is in flight.

`include "line_follow_motor_steering_top_assert.svh"

module line_follow_motor_steering_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lfms_pkg::in_beat_t   in_beat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lfms_pkg::out_beat_t  out_beat
);

    // configuration registers
    logic [15:0] base_power_reg;
    logic [7:0]  steer_gain_reg;
    logic [9:0]  left_white_reg, left_gray_reg, left_black_reg;
    logic [9:0]  right_white_reg, right_gray_reg, right_black_reg;

    // input stage
    logic        s1_valid_reg;
    logic [3:0]  s1_code_reg;
    logic        s1_shake_reg;
    logic [15:0] s1_step_reg;
    logic        s1_button_reg;

    // control state
    logic [15:0] heading_reg, heading_next;
    logic [15:0] forward_reg, forward_next;
    logic [1:0]  turning_reg, turning_next;
    logic        lock_reg, lock_next;
    logic [8:0]  timer_reg, timer_next;
    logic        mode_reg, mode_next;

    // result stage
    logic                out_valid_reg;
    lfms_pkg::out_beat_t out_beat_reg, out_beat_next;

    logic advance, in_fire, s1_load, s2_fire;

    // handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;
    assign s1_load  = !s1_valid_reg || advance;
    assign s2_fire  = s1_valid_reg && advance;

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_power_reg  <= lfms_pkg::BASE_POWER_RST;
            steer_gain_reg  <= lfms_pkg::STEER_GAIN_RST;
            left_white_reg  <= lfms_pkg::LEFT_WHITE_RST;
            left_gray_reg   <= lfms_pkg::LEFT_GRAY_RST;
            left_black_reg  <= lfms_pkg::LEFT_BLACK_RST;
            right_white_reg <= lfms_pkg::RIGHT_WHITE_RST;
            right_gray_reg  <= lfms_pkg::RIGHT_GRAY_RST;
            right_black_reg <= lfms_pkg::RIGHT_BLACK_RST;
        end
        else if (cfg_we)
        begin
            case (lfms_pkg::cfg_index_t'(cfg_index))
                lfms_pkg::CFG_BASE_POWER:  base_power_reg  <= cfg_data;
                lfms_pkg::CFG_STEER_GAIN:  steer_gain_reg  <= cfg_data[7:0];
                lfms_pkg::CFG_LEFT_WHITE:  left_white_reg  <= cfg_data[9:0];
                lfms_pkg::CFG_LEFT_GRAY:   left_gray_reg   <= cfg_data[9:0];
                lfms_pkg::CFG_LEFT_BLACK:  left_black_reg  <= cfg_data[9:0];
                lfms_pkg::CFG_RIGHT_WHITE: right_white_reg <= cfg_data[9:0];
                lfms_pkg::CFG_RIGHT_GRAY:  right_gray_reg  <= cfg_data[9:0];
                lfms_pkg::CFG_RIGHT_BLACK: right_black_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // input stage: shake sum, scaled gyro rate, sensor classes
    logic [15:0] ax_mag, ay_mag, az_mag, rate_mag;
    logic [12:0] shake_sum;
    logic [31:0] rate_prod;
    logic [15:0] rate_quot, step_in;
    logic        rate_active;
    logic [3:0]  code_in;

    always_comb
    begin
        ax_mag    = lfms_pkg::mag16(in_beat.accel_x);
        ay_mag    = lfms_pkg::mag16(in_beat.accel_y);
        az_mag    = lfms_pkg::mag16(in_beat.accel_z);
        shake_sum = 13'(ax_mag[15:5]) + 13'(ay_mag[15:5]) + 13'(az_mag[15:5]);

        rate_mag    = lfms_pkg::mag16(in_beat.gyro_rate);
        rate_prod   = 32'(rate_mag) * 32'(lfms_pkg::RATE_RECIP);
        rate_quot   = 16'(rate_prod >> lfms_pkg::RATE_SHIFT);
        rate_active = (in_beat.gyro_rate > lfms_pkg::RATE_HIGH)
                   || (in_beat.gyro_rate < lfms_pkg::RATE_LOW);
        if (!rate_active)
            step_in = 16'd0;
        else if (in_beat.gyro_rate[15])
            step_in = 16'd0 - rate_quot;
        else
            step_in = rate_quot;

        code_in = lfms_pkg::pair_code(
            lfms_pkg::classify(in_beat.ir_left, left_white_reg, left_gray_reg,
                               left_black_reg),
            lfms_pkg::classify(in_beat.ir_right, right_white_reg, right_gray_reg,
                               right_black_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_code_reg   <= code_in;
            s1_shake_reg  <= shake_sum > lfms_pkg::SHAKE_LIMIT;
            s1_step_reg   <= step_in;
            s1_button_reg <= in_beat.button;
        end
    end

    // result stage: lockout, heading and steering
    logic [8:0]  timer_a;
    logic        lock_a;
    logic [15:0] forward_eff, err, err_mag, room;
    logic [23:0] corr;
    logic        saturate;
    logic [15:0] m_left, m_right;

    always_comb
    begin
        // lockout timer
        if (timer_reg > lfms_pkg::LOCK_TICKS)
        begin
            timer_a = 9'd0;
            lock_a  = 1'b0;
        end
        else
        begin
            timer_a = timer_reg;
            lock_a  = lock_reg;
        end
        timer_next = (timer_a != 9'd0) ? timer_a + 9'd1 : 9'd0;
        lock_next  = lock_a;
        mode_next  = mode_reg;

        // shake toggles light mode
        if (!lock_a && s1_shake_reg)
        begin
            mode_next  = !mode_reg;
            timer_next = 9'd1;
            lock_next  = 1'b1;
        end

        heading_next = heading_reg + s1_step_reg;

        // heading error against stored forward heading, or the new heading while the button is set
        forward_eff = s1_button_reg ? heading_next : forward_reg;
        err         = heading_next - forward_eff;
        err_mag     = lfms_pkg::mag16(err);
        corr        = 24'(err_mag) * 24'(steer_gain_reg);
        room        = lfms_pkg::FULL_DUTY - base_power_reg;
        saturate    = corr >= 24'(room);

        forward_next = forward_reg;
        turning_next = turning_reg;
        m_left       = base_power_reg;
        m_right      = base_power_reg;

        case (s1_code_reg)
            lfms_pkg::DIR_BOTH_WHITE:
            begin
                if (turning_reg != lfms_pkg::TURN_NONE)
                begin
                    forward_next = heading_next;
                    turning_next = lfms_pkg::TURN_NONE;
                end
                else
                begin
                    forward_next = forward_eff;
                    if ($signed(err) > lfms_pkg::DRIFT_RIGHT)
                    begin
                        m_left  = saturate ? lfms_pkg::FULL_DUTY
                                           : base_power_reg + corr[15:0];
                        m_right = saturate ? lfms_pkg::WEAK_DUTY
                                           : base_power_reg - corr[15:0];
                    end
                    else if ($signed(err) < lfms_pkg::DRIFT_LEFT)
                    begin
                        m_left  = saturate ? lfms_pkg::WEAK_DUTY
                                           : base_power_reg - corr[15:0];
                        m_right = saturate ? lfms_pkg::FULL_DUTY
                                           : base_power_reg + corr[15:0];
                    end
                end
            end
            lfms_pkg::DIR_WHITE_GRAY:
            begin
                m_left       = lfms_pkg::PIVOT_DUTY;
                m_right      = 16'd0;
                turning_next = lfms_pkg::TURN_RIGHT;
            end
            lfms_pkg::DIR_BLACK_BLACK:
            begin
                m_left       = 16'd0;
                m_right      = 16'd0;
                turning_next = lfms_pkg::TURN_RIGHT;
            end
            lfms_pkg::DIR_GRAY_WHITE:
            begin
                m_left       = 16'd0;
                m_right      = lfms_pkg::PIVOT_DUTY;
                turning_next = lfms_pkg::TURN_LEFT;
            end
            default: ;
        endcase

        out_beat_next.motor_left     = m_left;
        out_beat_next.motor_right    = m_right;
        out_beat_next.direction_code = s1_code_reg;
        out_beat_next.light_mode     = mode_next;
    end

    // control state update, one tick per result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg <= 16'd0;
            forward_reg <= 16'd0;
            turning_reg <= lfms_pkg::TURN_NONE;
            lock_reg    <= 1'b0;
            timer_reg   <= 9'd0;
            mode_reg    <= 1'b0;
        end
        else if (s2_fire)
        begin
            heading_reg <= heading_next;
            forward_reg <= forward_next;
            turning_reg <= turning_next;
            lock_reg    <= lock_next;
            timer_reg   <= timer_next;
            mode_reg    <= mode_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    // checks
    `LFMS_ASSERT(a_lock_tracks_timer, lock_reg == (timer_reg != 9'd0))
    `LFMS_ASSERT(a_timer_bound, timer_reg <= lfms_pkg::LOCK_TICKS + 9'd1)
    `LFMS_ASSERT(a_turning_code, turning_reg != 2'd3)
    `LFMS_ASSERT(a_code_range, !out_valid_reg || out_beat_reg.direction_code <= 4'd8)
    `LFMS_ASSERT(a_stall_only_when_full, !in_stall || (s1_valid_reg && out_valid_reg))
    `LFMS_ASSERT_NEXT(a_tick_reaches_result, s1_valid_reg && advance, out_valid_reg)

endmodule

// File: dv/steering_scoreboard_pkg.sv
`timescale 1ns / 1ps

package steering_scoreboard_pkg;

    import lfms_pkg::*;

    // gyro rate is scaled down by this before it joins the heading
    localparam int RATE_STEP_DIV = 10;

    class duty_scoreboard;

        // shadow of the configuration registers
        logic [15:0] base_power;
        logic [7:0]  steer_gain;
        logic [9:0]  left_white;
        logic [9:0]  left_gray;
        logic [9:0]  left_black;
        logic [9:0]  right_white;
        logic [9:0]  right_gray;
        logic [9:0]  right_black;

        // controller state carried from tick to tick
        logic [15:0] heading_sum;
        logic [15:0] forward_heading;
        logic [1:0]  turning;
        logic        shake_lock;
        logic [8:0]  shake_timer;
        logic        mode_flag;

        out_beat_t   expected_duties[$];
        int unsigned mismatch_count;

        function new();
            base_power      = BASE_POWER_RST;
            steer_gain      = STEER_GAIN_RST;
            left_white      = LEFT_WHITE_RST;
            left_gray       = LEFT_GRAY_RST;
            left_black      = LEFT_BLACK_RST;
            right_white     = RIGHT_WHITE_RST;
            right_gray      = RIGHT_GRAY_RST;
            right_black     = RIGHT_BLACK_RST;
            heading_sum     = '0;
            forward_heading = '0;
            turning         = TURN_NONE;
            shake_lock      = 1'b0;
            shake_timer     = '0;
            mode_flag       = 1'b0;
            mismatch_count  = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] val);
            case (idx)
                CFG_BASE_POWER:  base_power  = val;
                CFG_STEER_GAIN:  steer_gain  = val[7:0];
                CFG_LEFT_WHITE:  left_white  = val[9:0];
                CFG_LEFT_GRAY:   left_gray   = val[9:0];
                CFG_LEFT_BLACK:  left_black  = val[9:0];
                CFG_RIGHT_WHITE: right_white = val[9:0];
                CFG_RIGHT_GRAY:  right_gray  = val[9:0];
                CFG_RIGHT_BLACK: right_black = val[9:0];
                default: ;
            endcase
        endfunction

        static function int unsigned abs_of(int v);
            return (v < 0) ? -v : v;
        endfunction

        // nearest reference level, gray wins any tie
        static function tone_t nearest_tone(int x, int w, int g, int b);
            int unsigned to_gray;
            to_gray = abs_of(x - g);
            if (abs_of(x - w) < to_gray)
                return TONE_WHITE;
            if (abs_of(x - b) < to_gray)
                return TONE_BLACK;
            return TONE_GRAY;
        endfunction

        static function logic [3:0] tone_pair_code(tone_t l, tone_t r);
            logic [3:0] c;
            case (l)
                TONE_WHITE:
                    case (r)
                        TONE_GRAY:  c = DIR_WHITE_GRAY;
                        TONE_BLACK: c = DIR_WHITE_BLACK;
                        default:    c = DIR_BOTH_WHITE;
                    endcase
                TONE_GRAY:
                    case (r)
                        TONE_GRAY:  c = DIR_GRAY_GRAY;
                        TONE_BLACK: c = DIR_GRAY_BLACK;
                        default:    c = DIR_GRAY_WHITE;
                    endcase
                default:
                    case (r)
                        TONE_GRAY:  c = DIR_BLACK_GRAY;
                        TONE_BLACK: c = DIR_BLACK_BLACK;
                        default:    c = DIR_BLACK_WHITE;
                    endcase
            endcase
            return c;
        endfunction

        // advance the state by one accepted tick and queue its duties
        function void note_tick(in_beat_t b);
            int          ax;
            int          ay;
            int          az;
            int          rate;
            int          err;
            int unsigned shake_sum;
            int unsigned corr;
            int unsigned room;
            logic [15:0] diff;
            logic [15:0] m1;
            logic [15:0] m2;
            logic [3:0]  code;
            out_beat_t   e;

            ax   = $signed(b.accel_x);
            ay   = $signed(b.accel_y);
            az   = $signed(b.accel_z);
            rate = $signed(b.gyro_rate);

            // lockout timer
            if (shake_timer > LOCK_TICKS)
            begin
                shake_timer = '0;
                shake_lock  = 1'b0;
            end
            if (shake_timer != 0)
                shake_timer = shake_timer + 9'd1;

            // shake detection
            if (!shake_lock)
            begin
                shake_sum = (abs_of(ax) >> 5) + (abs_of(ay) >> 5) + (abs_of(az) >> 5);
                if (shake_sum > SHAKE_LIMIT)
                begin
                    mode_flag   = ~mode_flag;
                    shake_timer = 9'd1;
                    shake_lock  = 1'b1;
                end
            end

            // heading integration outside the deadband
            if (rate > int'(RATE_HIGH) || rate < int'(RATE_LOW))
                heading_sum = heading_sum + 16'(rate / RATE_STEP_DIV);

            code = tone_pair_code(
                nearest_tone(b.ir_left, left_white, left_gray, left_black),
                nearest_tone(b.ir_right, right_white, right_gray, right_black));

            // steering
            m1 = base_power;
            m2 = base_power;
            if (code == DIR_BOTH_WHITE)
            begin
                if (turning != TURN_NONE)
                begin
                    forward_heading = heading_sum;
                    turning         = TURN_NONE;
                end
                else
                begin
                    if (b.button)
                        forward_heading = heading_sum;
                    diff = heading_sum - forward_heading;
                    err  = $signed(diff);
                    corr = abs_of(err) * steer_gain;
                    room = FULL_DUTY - base_power;
                    if (err > int'(DRIFT_RIGHT))
                    begin
                        if (corr >= room)
                        begin
                            m1 = FULL_DUTY;
                            m2 = WEAK_DUTY;
                        end
                        else
                        begin
                            m1 = 16'(base_power + corr);
                            m2 = 16'(base_power - corr);
                        end
                    end
                    else if (err < int'(DRIFT_LEFT))
                    begin
                        if (corr >= room)
                        begin
                            m1 = WEAK_DUTY;
                            m2 = FULL_DUTY;
                        end
                        else
                        begin
                            m1 = 16'(base_power - corr);
                            m2 = 16'(base_power + corr);
                        end
                    end
                end
            end
            else if (code == DIR_WHITE_GRAY)
            begin
                m1      = PIVOT_DUTY;
                m2      = '0;
                turning = TURN_RIGHT;
            end
            else if (code == DIR_BLACK_BLACK)
            begin
                m1      = '0;
                m2      = '0;
                turning = TURN_RIGHT;
            end
            else if (code == DIR_GRAY_WHITE)
            begin
                m1      = '0;
                m2      = PIVOT_DUTY;
                turning = TURN_LEFT;
            end

            e.motor_left     = m1;
            e.motor_right    = m2;
            e.direction_code = code;
            e.light_mode     = mode_flag;
            expected_duties.push_back(e);
        endfunction

        // compare one result beat against the oldest queued expectation
        function void check_duties(out_beat_t got);
            out_beat_t want;
            if (expected_duties.size() == 0)
            begin
                $error("result beat with no tick outstanding");
                mismatch_count++;
                return;
            end
            want = expected_duties.pop_front();
            if (got.motor_left !== want.motor_left)
            begin
                $error("motor_left expected %0d actual %0d", want.motor_left, got.motor_left);
                mismatch_count++;
            end
            if (got.motor_right !== want.motor_right)
            begin
                $error("motor_right expected %0d actual %0d", want.motor_right, got.motor_right);
                mismatch_count++;
            end
            if (got.direction_code !== want.direction_code)
            begin
                $error("direction_code expected %0d actual %0d",
                       want.direction_code, got.direction_code);
                mismatch_count++;
            end
            if (got.light_mode !== want.light_mode)
            begin
                $error("light_mode expected %0d actual %0d", want.light_mode, got.light_mode);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import lfms_pkg::*;
    import steering_scoreboard_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_beat_t    in_beat   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_beat_t   out_beat;

    duty_scoreboard duty_board = new();

    // traffic shaping shared by sender and receiver
    bit calm_stretch  = 1'b0;
    bit pressure_req  = 1'b0;
    bit pressure_done = 1'b0;
    int hold_left     = 0;

    // current run of sensor tones for the random ticks
    tone_t run_left_tone  = TONE_WHITE;
    tone_t run_right_tone = TONE_WHITE;
    int    run_ticks      = 0;

    line_follow_motor_steering_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: random stalls plus one long hold-off to back the pipe up
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (pressure_req && !pressure_done)
        begin
            out_stall     <= 1'b1;
            hold_left     <= 60;
            pressure_done <= 1'b1;
        end
        else
        begin
            out_stall <= !calm_stretch && ($urandom_range(0, 99) < 9);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            duty_board.check_duties(out_beat);
    end

    function automatic in_beat_t make_tick(int ax, int ay, int az, int rate,
                                           int irl, int irr, bit btn);
        in_beat_t t;
        t.accel_x   = 16'(ax);
        t.accel_y   = 16'(ay);
        t.accel_z   = 16'(az);
        t.gyro_rate = 16'(rate);
        t.ir_left   = 10'(irl);
        t.ir_right  = 10'(irr);
        t.button    = btn;
        return t;
    endfunction

    function automatic tone_t random_tone();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return TONE_WHITE;
        if (r < 75)
            return TONE_GRAY;
        return TONE_BLACK;
    endfunction

    // sensor reading close to the level of the wanted tone, sometimes anywhere
    function automatic logic [9:0] reading_near(tone_t t, logic [9:0] w, logic [9:0] g,
                                                logic [9:0] b);
        int level;
        int v;
        level = (t == TONE_WHITE) ? int'(w) : (t == TONE_GRAY) ? int'(g) : int'(b);
        if ($urandom_range(0, 99) < 20)
            return 10'($urandom);
        v = level + int'($urandom_range(0, 40)) - 20;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return 10'(v);
    endfunction

    function automatic logic [15:0] accel_sample(bit shaking);
        int r;
        int m;
        if (shaking)
        begin
            if ($urandom_range(0, 9) == 0)
                return 16'h8000;
            m = $urandom_range(27000, 32767);
            return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
        end
        r = $urandom_range(0, 99);
        if (r < 90)
            return 16'(int'($urandom_range(0, 4000)) - 2000);
        return 16'($urandom);
    endfunction

    // gyro rate: deadband edges, gentle turns, hard turns, anything
    function automatic logic [15:0] gyro_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            case ($urandom_range(0, 4))
                0: return 16'(50);
                1: return 16'(51);
                2: return 16'(-40);
                3: return 16'(-41);
                default: return 16'(0);
            endcase
        end
        if (r < 70)
            return 16'(int'($urandom_range(0, 600)) - 300);
        if (r < 90)
            return 16'(int'($urandom_range(0, 6000)) - 3000);
        return 16'($urandom);
    endfunction

    function automatic in_beat_t next_random_tick();
        in_beat_t t;
        bit       shaking;
        if (run_ticks == 0)
        begin
            run_left_tone  = random_tone();
            run_right_tone = random_tone();
            run_ticks      = $urandom_range(1, 8);
        end
        run_ticks--;
        shaking     = ($urandom_range(0, 99) < 4);
        t.accel_x   = accel_sample(shaking);
        t.accel_y   = accel_sample(shaking);
        t.accel_z   = accel_sample(shaking);
        t.gyro_rate = gyro_sample();
        t.ir_left   = reading_near(run_left_tone, duty_board.left_white,
                                   duty_board.left_gray, duty_board.left_black);
        t.ir_right  = reading_near(run_right_tone, duty_board.right_white,
                                   duty_board.right_gray, duty_board.right_black);
        t.button    = ($urandom_range(0, 99) < 8);
        return t;
    endfunction

    // offer one tick, with an occasional one-cycle gap before it, and hold it until taken
    task automatic send_tick(input in_beat_t t);
        int gap;
        gap = 0;
        if (!calm_stretch && $urandom_range(0, 99) < 9)
            gap = 1;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= t;
        do
            @(posedge clk);
        while (in_stall);
        duty_board.note_tick(t);
    endtask

    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (duty_board.expected_duties.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        duty_board.write_reg(idx, val);
    endtask

    task automatic load_settings(input logic [15:0] base, input logic [15:0] gain,
                                 input logic [15:0] lw, input logic [15:0] lg,
                                 input logic [15:0] lb, input logic [15:0] rw,
                                 input logic [15:0] rg, input logic [15:0] rb);
        drain_ticks();
        set_reg(CFG_BASE_POWER, base);
        set_reg(CFG_STEER_GAIN, gain);
        set_reg(CFG_LEFT_WHITE, lw);
        set_reg(CFG_LEFT_GRAY, lg);
        set_reg(CFG_LEFT_BLACK, lb);
        set_reg(CFG_RIGHT_WHITE, rw);
        set_reg(CFG_RIGHT_GRAY, rg);
        set_reg(CFG_RIGHT_BLACK, rb);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input int calm_len, input int pressure_at);
        for (int i = 0; i < count; i++)
        begin
            calm_stretch <= (i < calm_len);
            if (i == pressure_at)
                pressure_req <= 1'b1;
            send_tick(next_random_tick());
        end
        calm_stretch <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        in_beat_t directed[$];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // heading capture, deadband edges, drift both ways, saturation
        directed.push_back(make_tick(0, 0, 0, 0, 1023, 1023, 1'b1));
        directed.push_back(make_tick(0, 0, 0, 51, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 100, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 32767, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, -32768, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 50, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, -40, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, -41, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, -200, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, -32768, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 1023, 1023, 1'b1));
        // pivots, stop and return from a turn
        directed.push_back(make_tick(0, 0, 0, 0, 1023, 370, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 370, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 1023, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 0, 0, 1'b0));
        // the remaining sensor pairs
        directed.push_back(make_tick(0, 0, 0, 0, 1023, 0, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 370, 370, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 370, 0, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 0, 370, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 0, 1023, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 1023, 1023, 1'b0));
        // readings exactly midway between two levels
        directed.push_back(make_tick(0, 0, 0, 0, 535, 535, 1'b0));
        directed.push_back(make_tick(0, 0, 0, 0, 194, 205, 1'b0));
        // shake exactly at the limit, just over it, then again while locked out
        directed.push_back(make_tick(26656, 26656, 26688, 0, 1023, 1023, 1'b0));
        directed.push_back(make_tick(26656, 26656, -26720, 0, 1023, 1023, 1'b0));
        directed.push_back(make_tick(32767, -32768, 32767, 0, 1023, 1023, 1'b0));
        foreach (directed[i])
            send_tick(directed[i]);

        // zero base with full gain, widest level spread
        load_settings(16'h0000, 16'd255, 16'd1023, 16'd512, 16'd0,
                      16'd1023, 16'd512, 16'd0);
        run_random(150, 0, -1);

        // full base with zero gain, left levels collapsed to zero
        load_settings(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0,
                      16'd700, 16'd370, 16'd40);
        run_random(100, 0, -1);

        // arbitrary settings, starting with a stretch of uninterrupted traffic
        load_settings(16'($urandom), 16'($urandom_range(0, 255)),
                      16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                      16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                      16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)));
        run_random(150, 80, -1);

        // back to the power-up settings, with the long receiver hold-off
        load_settings(BASE_POWER_RST, 16'(STEER_GAIN_RST), 16'(LEFT_WHITE_RST),
                      16'(LEFT_GRAY_RST), 16'(LEFT_BLACK_RST), 16'(RIGHT_WHITE_RST),
                      16'(RIGHT_GRAY_RST), 16'(RIGHT_BLACK_RST));
        run_random(200, 0, 20);

        drain_ticks();
        repeat (8) @(posedge clk);
        if (duty_board.mismatch_count == 0 && duty_board.expected_duties.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/lfms_pkg.sv
sv/line_follow_motor_steering_top.sv
dv/steering_scoreboard_pkg.sv
dv/tb_top.sv
